FILE: rtl/ositp_pkg.sv
// ----------------------------------------------------------------------------
// Operator stack package
// Shared constants, codes and types of the shunting-yard operator stack.
// ----------------------------------------------------------------------------
package ositp_pkg;

   localparam int STACK_DEPTH = 16;
   localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
   localparam int CODE_W      = 8;
   localparam int PRIO_W      = 4;
   localparam int ERR_W       = 2;

   localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
   localparam logic [ERR_W-1:0] ERR_UNMATCHED = 2'd1;
   localparam logic [ERR_W-1:0] ERR_OVERFLOW  = 2'd2;

   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic [PRIO_W-1:0] prio;
   } entry_type;

   typedef enum logic [1:0] {
      SHIFT_HOLD,
      SHIFT_PUSH,
      SHIFT_POP
   } shift_type;

   typedef enum logic [1:0] {
      KIND_OPEN,
      KIND_CLOSE,
      KIND_OPER
   } kind_type;

   typedef enum logic {
      ST_IDLE,
      ST_WORK
   } state_type;

   // What the controller sees of the top of the cell chain.
   typedef struct packed {
      entry_type top;
      entry_type next;
   } stack_view_type;

endpackage

FILE: rtl/ositp_if.sv
// ----------------------------------------------------------------------------
// Operator stack channels
// Valid/ready channels for incoming tokens and emitted postfix results.
// ----------------------------------------------------------------------------
interface ositp_req_if;
   logic                        valid;
   logic                        ready;
   logic [ositp_pkg::CODE_W-1:0] token_code;
   logic [ositp_pkg::PRIO_W-1:0] priority_req;
   logic                        is_open;

   modport source (output valid, token_code, priority_req, is_open, input ready);
   modport sink   (input valid, token_code, priority_req, is_open, output ready);
endinterface

interface ositp_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [ositp_pkg::CODE_W-1:0] popped_code;
   logic                        has_op;
   logic                        last;
   logic [ositp_pkg::ERR_W-1:0]  error;

   modport source (output valid, popped_code, has_op, last, error, input ready);
   modport sink   (input valid, popped_code, has_op, last, error, output ready);
endinterface

FILE: rtl/ositp_cell.sv
// ----------------------------------------------------------------------------
// Operator stack cell
// One stack slot; takes the entry above on a push, the entry below on a pop.
// ----------------------------------------------------------------------------
module ositp_cell (
   input  logic                  clock,
   input  ositp_pkg::shift_type  shift,
   input  ositp_pkg::entry_type  above,
   input  ositp_pkg::entry_type  below,
   output ositp_pkg::entry_type  entry
);

   ositp_pkg::entry_type entry_ff;
   ositp_pkg::entry_type entry_in;

   always_comb begin
      case (shift)
         ositp_pkg::SHIFT_PUSH: entry_in = above;
         ositp_pkg::SHIFT_POP:  entry_in = below;
         default:               entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

FILE: rtl/ositp_ctrl.sv
// ----------------------------------------------------------------------------
// Operator stack controller
// Token sequencer: one push, pop or drop per unstalled cycle; emits results.
// ----------------------------------------------------------------------------
module ositp_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   ositp_req_if.sink                 req_chan,
   ositp_rsp_if.source               rsp_chan,
   input  ositp_pkg::stack_view_type view,
   output ositp_pkg::shift_type      shift,
   output ositp_pkg::entry_type      push_entry
);

   ositp_pkg::state_type                 state_ff, state_in;
   logic [ositp_pkg::COUNT_W-1:0]        count_ff, count_in;
   ositp_pkg::kind_type                  kind_ff, kind_in;
   logic [ositp_pkg::CODE_W-1:0]         tok_code_ff, tok_code_in;
   logic [ositp_pkg::PRIO_W-1:0]         tok_prio_ff, tok_prio_in;

   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [ositp_pkg::CODE_W-1:0]         rsp_code_ff, rsp_code_in;
   logic                                 rsp_has_ff, rsp_has_in;
   logic                                 rsp_last_ff, rsp_last_in;
   logic [ositp_pkg::ERR_W-1:0]          rsp_err_ff, rsp_err_in;

   logic                                 accept;
   logic                                 slot_free;
   logic                                 empty;
   logic                                 full;
   logic                                 one_left;

   // Decision of the current work cycle.
   ositp_pkg::shift_type                 act_shift;
   logic                                 act_emit;
   logic                                 act_has;
   logic                                 act_last;
   logic [ositp_pkg::ERR_W-1:0]          act_err;
   logic                                 act_done;

   assign accept    = req_chan.valid && req_chan.ready;
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign empty     = (count_ff == '0);
   assign full      = (count_ff == ositp_pkg::COUNT_W'(ositp_pkg::STACK_DEPTH));
   assign one_left  = (count_ff == ositp_pkg::COUNT_W'(1));

   always_comb begin
      act_shift = ositp_pkg::SHIFT_HOLD;
      act_emit  = 1'b0;
      act_has   = 1'b0;
      act_last  = 1'b0;
      act_err   = ositp_pkg::ERR_NONE;
      act_done  = 1'b0;
      if (state_ff == ositp_pkg::ST_WORK && slot_free) begin
         case (kind_ff)
            ositp_pkg::KIND_OPEN: begin
               act_done = 1'b1;
               if (full) begin
                  act_emit = 1'b1;
                  act_last = 1'b1;
                  act_err  = ositp_pkg::ERR_OVERFLOW;
               end else begin
                  act_shift = ositp_pkg::SHIFT_PUSH;
               end
            end
            ositp_pkg::KIND_CLOSE: begin
               if (empty) begin
                  act_emit = 1'b1;
                  act_last = 1'b1;
                  act_err  = ositp_pkg::ERR_UNMATCHED;
                  act_done = 1'b1;
               end else if (view.top.prio == '0) begin
                  // The matching open parenthesis is dropped without a result.
                  act_shift = ositp_pkg::SHIFT_POP;
                  act_done  = 1'b1;
               end else begin
                  act_shift = ositp_pkg::SHIFT_POP;
                  act_emit  = 1'b1;
                  act_has   = 1'b1;
                  if (one_left) begin
                     act_last = 1'b1;
                     act_err  = ositp_pkg::ERR_UNMATCHED;
                     act_done = 1'b1;
                  end else if (view.next.prio == '0) begin
                     act_last = 1'b1;
                  end
               end
            end
            default: begin
               if (!empty && view.top.prio >= tok_prio_ff) begin
                  act_shift = ositp_pkg::SHIFT_POP;
                  act_emit  = 1'b1;
                  act_has   = 1'b1;
                  // The push that follows a pop never overflows, so it is silent.
                  act_last  = one_left || (view.next.prio < tok_prio_ff);
               end else if (full) begin
                  act_emit = 1'b1;
                  act_last = 1'b1;
                  act_err  = ositp_pkg::ERR_OVERFLOW;
                  act_done = 1'b1;
               end else begin
                  act_shift = ositp_pkg::SHIFT_PUSH;
                  act_done  = 1'b1;
               end
            end
         endcase
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ositp_pkg::ST_IDLE: if (accept) state_in = ositp_pkg::ST_WORK;
         ositp_pkg::ST_WORK: if (act_done) state_in = ositp_pkg::ST_IDLE;
         default:            state_in = ositp_pkg::ST_IDLE;
      endcase
   end

   // Outputs and datapath.
   always_comb begin
      req_chan.ready = (state_ff == ositp_pkg::ST_IDLE);
      shift          = act_shift;
      push_entry     = '{code: tok_code_ff, prio: tok_prio_ff};

      kind_in     = kind_ff;
      tok_code_in = tok_code_ff;
      tok_prio_in = tok_prio_ff;
      if (accept) begin
         tok_code_in = req_chan.token_code;
         tok_prio_in = req_chan.priority_req;
         if (req_chan.priority_req != '0) begin
            kind_in = ositp_pkg::KIND_OPER;
         end else if (req_chan.is_open) begin
            kind_in = ositp_pkg::KIND_OPEN;
         end else begin
            kind_in = ositp_pkg::KIND_CLOSE;
         end
      end

      unique case (act_shift)
         ositp_pkg::SHIFT_PUSH: count_in = count_ff + ositp_pkg::COUNT_W'(1);
         ositp_pkg::SHIFT_POP:  count_in = count_ff - ositp_pkg::COUNT_W'(1);
         default:               count_in = count_ff;
      endcase

      rsp_code_in = rsp_code_ff;
      rsp_has_in  = rsp_has_ff;
      rsp_last_in = rsp_last_ff;
      rsp_err_in  = rsp_err_ff;
      if (act_emit) begin
         rsp_valid_in = 1'b1;
         rsp_code_in  = act_has ? view.top.code : '0;
         rsp_has_in   = act_has;
         rsp_last_in  = act_last;
         rsp_err_in   = act_err;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ositp_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      tok_code_ff <= tok_code_in;
      tok_prio_ff <= tok_prio_in;
      rsp_code_ff <= rsp_code_in;
      rsp_has_ff  <= rsp_has_in;
      rsp_last_ff <= rsp_last_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.popped_code = rsp_code_ff;
   assign rsp_chan.has_op      = rsp_has_ff;
   assign rsp_chan.last        = rsp_last_ff;
   assign rsp_chan.error       = rsp_err_ff;

endmodule

FILE: rtl/operator_stack_infix_to_postfix.sv
// ----------------------------------------------------------------------------
// Shunting-yard operator stack
// Turns operator and parenthesis tokens into the postfix operator stream.
// ----------------------------------------------------------------------------
// The stack is a row of cells, top entry in the first cell, that all shift
// down on a push and up on a pop, one entry per cycle unless the result
// channel stalls. A token is taken while the controller is idle and is then
// worked off in steps: each popped operator yields one transaction on the
// result channel, and the token ends with the final push or parenthesis drop.
// The next token is not taken before that. An unmatched close has no
// parenthesis to drop and is done with its last pop, or with a bare report on
// an empty stack. An unmatched close reports error 1 on its last result, and a
// push onto a full stack is dropped and reports error 2 in a result without an
// operator.
module operator_stack_infix_to_postfix (
   input  logic        clock,
   input  logic        reset,
   ositp_req_if.sink   req_chan,
   ositp_rsp_if.source rsp_chan
);

   ositp_pkg::entry_type      entries [ositp_pkg::STACK_DEPTH];
   ositp_pkg::entry_type      push_entry;
   ositp_pkg::shift_type      shift;
   ositp_pkg::stack_view_type view;

   assign view.top  = entries[0];
   assign view.next = entries[1];

   ositp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .view       (view),
      .shift      (shift),
      .push_entry (push_entry)
   );

   for (genvar i = 0; i < ositp_pkg::STACK_DEPTH; i++) begin : g_cell
      ositp_pkg::entry_type above;
      ositp_pkg::entry_type below;

      if (i == 0) begin : g_top
         assign above = push_entry;
      end else begin : g_mid
         assign above = entries[i-1];
      end

      if (i == ositp_pkg::STACK_DEPTH - 1) begin : g_bottom
         assign below = entries[i];
      end else begin : g_inner
         assign below = entries[i+1];
      end

      ositp_cell u_cell (
         .clock (clock),
         .shift (shift),
         .above (above),
         .below (below),
         .entry (entries[i])
      );
   end

endmodule

FILE: rtl/ositp_checker.sv
// ----------------------------------------------------------------------------
// Operator stack checker
// Port-level assertions for the operator stack, attached by bind.
// ----------------------------------------------------------------------------
module ositp_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [ositp_pkg::CODE_W-1:0] rsp_popped_code,
   input logic                         rsp_has_op,
   input logic                         rsp_last,
   input logic [ositp_pkg::ERR_W-1:0]  rsp_error
);

   // A stalled result transaction keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_popped_code)
         && $stable(rsp_has_op) && $stable(rsp_last) && $stable(rsp_error))
      else $error("result payload changed while stalled");

   // One token is handled at a time.
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("token taken while another is in work");

   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error != ositp_pkg::ERR_NONE |-> rsp_last)
      else $error("error reported on a result that is not the last");

   a_err_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_op |-> rsp_last && rsp_popped_code == '0
         && rsp_error != ositp_pkg::ERR_NONE)
      else $error("malformed error-only result");

   a_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error == ositp_pkg::ERR_OVERFLOW |-> !rsp_has_op)
      else $error("overflow reported with an operator");

endmodule

bind operator_stack_infix_to_postfix ositp_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_popped_code (rsp_chan.popped_code),
   .rsp_has_op      (rsp_chan.has_op),
   .rsp_last        (rsp_chan.last),
   .rsp_error       (rsp_chan.error)
);

FILE: test/postfix_checker.sv
// ----------------------------------------------------------------------------
// Postfix result checker
// Watches the token and result channels of the operator stack. It keeps its
// own copy of the stack, works out the postfix results for every accepted
// token, and compares each accepted result with the oldest one still due.
// ----------------------------------------------------------------------------
module postfix_checker (
   input  logic  clock,
   input  logic  reset,
   ositp_req_if  req_mon,
   ositp_rsp_if  rsp_mon,
   output int    mismatch_count,
   output int    pending_results,
   output int    tokens_seen,
   output int    results_seen,
   output int    unmatched_seen,
   output int    overflow_seen
);

   typedef struct packed {
      logic [ositp_pkg::CODE_W-1:0] code;
      logic                         has_op;
      logic                         last;
      logic [ositp_pkg::ERR_W-1:0]  error;
   } postfix_out_type;

   ositp_pkg::entry_type op_stack [ositp_pkg::STACK_DEPTH];
   int                   stack_fill;
   postfix_out_type      token_batch [$];
   postfix_out_type      postfix_due [$];

   function automatic void pop_to_output();
      stack_fill--;
      token_batch.push_back('{op_stack[stack_fill].code, 1'b1, 1'b0,
                              ositp_pkg::ERR_NONE});
   endfunction

   function automatic void push_or_overflow(input logic [ositp_pkg::CODE_W-1:0] code,
                                            input logic [ositp_pkg::PRIO_W-1:0] prio);
      if (stack_fill >= ositp_pkg::STACK_DEPTH) begin
         token_batch.push_back('{'0, 1'b0, 1'b0, ositp_pkg::ERR_OVERFLOW});
      end else begin
         op_stack[stack_fill] = '{code: code, prio: prio};
         stack_fill++;
      end
   endfunction

   // Applies one token to the stack copy and queues the results it causes.
   function automatic void predict_postfix(input logic [ositp_pkg::CODE_W-1:0] code,
                                           input logic [ositp_pkg::PRIO_W-1:0] prio,
                                           input logic open_bit);
      ositp_pkg::kind_type kind;
      kind = (prio != '0) ? ositp_pkg::KIND_OPER :
             (open_bit ? ositp_pkg::KIND_OPEN : ositp_pkg::KIND_CLOSE);
      token_batch.delete();
      case (kind)
         ositp_pkg::KIND_OPEN: begin
            push_or_overflow(code, '0);
         end
         ositp_pkg::KIND_CLOSE: begin
            while (stack_fill > 0 && op_stack[stack_fill-1].prio != '0)
               pop_to_output();
            if (stack_fill == 0) begin
               // No open parenthesis was found: the close is unmatched.
               if (token_batch.size() > 0)
                  token_batch[token_batch.size()-1].error = ositp_pkg::ERR_UNMATCHED;
               else
                  token_batch.push_back('{'0, 1'b0, 1'b0, ositp_pkg::ERR_UNMATCHED});
            end else begin
               stack_fill--;
            end
         end
         default: begin
            while (stack_fill > 0 && op_stack[stack_fill-1].prio >= prio)
               pop_to_output();
            push_or_overflow(code, prio);
         end
      endcase
      if (token_batch.size() > 0)
         token_batch[token_batch.size()-1].last = 1'b1;
      foreach (token_batch[i])
         postfix_due.push_back(token_batch[i]);
   endfunction

   always @(posedge clock) begin
      postfix_out_type due;
      if (reset) begin
         stack_fill     = 0;
         postfix_due.delete();
         mismatch_count = 0;
         tokens_seen    = 0;
         results_seen   = 0;
         unmatched_seen = 0;
         overflow_seen  = 0;
      end else begin
         // Results always belong to earlier tokens, so they are checked first.
         if (rsp_mon.valid && rsp_mon.ready) begin
            results_seen++;
            if (rsp_mon.error == ositp_pkg::ERR_UNMATCHED) unmatched_seen++;
            if (rsp_mon.error == ositp_pkg::ERR_OVERFLOW) overflow_seen++;
            if (postfix_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("checker: result with nothing due: code %02h op %0b last %0b err %0d",
                           rsp_mon.popped_code, rsp_mon.has_op, rsp_mon.last,
                           rsp_mon.error);
            end else begin
               due = postfix_due.pop_front();
               if (rsp_mon.popped_code !== due.code || rsp_mon.has_op !== due.has_op ||
                   rsp_mon.last !== due.last || rsp_mon.error !== due.error) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("checker: result %0d mismatch", results_seen);
                     $display("   expected code %02h op %0b last %0b err %0d",
                              due.code, due.has_op, due.last, due.error);
                     $display("   got      code %02h op %0b last %0b err %0d",
                              rsp_mon.popped_code, rsp_mon.has_op, rsp_mon.last,
                              rsp_mon.error);
                  end
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            tokens_seen++;
            predict_postfix(req_mon.token_code, req_mon.priority_req, req_mon.is_open);
         end
      end
      pending_results = postfix_due.size();
   end

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// Operator stack testbench
// Feeds the shunting-yard operator stack with a directed token sequence and
// then with random expressions, operator ladders and stray tokens, under
// bursty token traffic and a stalling result channel. The checker beside the
// block predicts and compares every postfix result.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 175;
   localparam logic [ositp_pkg::PRIO_W-1:0] PRIO_PAREN = '0;
   localparam logic PAREN_OPEN  = 1'b1;
   localparam logic PAREN_CLOSE = 1'b0;

   typedef enum int {
      DRAIN_FREE,
      DRAIN_LIGHT,
      DRAIN_HALF,
      DRAIN_BURSTY
   } drain_kind_type;

   logic clock = 1'b0;
   logic reset;
   int   cycle_count = 0;
   int   burst_left = 0;
   int   items_sent = 0;

   int   mismatch_count;
   int   pending_results;
   int   tokens_seen;
   int   results_seen;
   int   unmatched_seen;
   int   overflow_seen;

   ositp_req_if req_chan ();
   ositp_rsp_if rsp_chan ();

   operator_stack_infix_to_postfix dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   postfix_checker postfix_chk (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_chan),
      .rsp_mon         (rsp_chan),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results),
      .tokens_seen     (tokens_seen),
      .results_seen    (results_seen),
      .unmatched_seen  (unmatched_seen),
      .overflow_seen   (overflow_seen)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top: timeout after %0d cycles", cycle_count);
         $display("tb_top: done, errors");
         $finish;
      end
   end

   // Holds one token on the channel until it is taken, then keeps the burst pacing.
   task automatic send_token(input logic [ositp_pkg::CODE_W-1:0] code,
                             input logic [ositp_pkg::PRIO_W-1:0] prio,
                             input logic open_bit);
      int gap;
      req_chan.valid        <= 1'b1;
      req_chan.token_code   <= code;
      req_chan.priority_req <= prio;
      req_chan.is_open      <= open_bit;
      do @(posedge clock); while (!req_chan.ready);
      items_sent++;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Stops sending until every predicted result has come out.
   task automatic wait_for_drain();
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (pending_results != 0);
      @(posedge clock);
   endtask

   // A well-formed fragment: operators and balanced parentheses.
   task automatic send_expression();
      int open_depth;
      int pick;
      open_depth = 0;
      repeat ($urandom_range(2, 10)) begin
         pick = $urandom_range(0, 99);
         if (pick < 25 && open_depth < 4) begin
            send_token(8'($urandom_range(0, 255)), PRIO_PAREN, PAREN_OPEN);
            open_depth++;
         end else if (pick < 45 && open_depth > 0) begin
            send_token(8'($urandom_range(0, 255)), PRIO_PAREN, PAREN_CLOSE);
            open_depth--;
         end else begin
            send_token(8'($urandom_range(0, 255)), 4'($urandom_range(1, 15)),
                       1'($urandom_range(0, 1)));
         end
      end
      while (open_depth > 0) begin
         send_token(8'($urandom_range(0, 255)), PRIO_PAREN, PAREN_CLOSE);
         open_depth--;
      end
   endtask

   // Rising priorities stack up without popping, then one close empties them.
   task automatic send_ladder();
      int prio;
      prio = $urandom_range(1, 3);
      while (prio <= 15) begin
         send_token(8'($urandom_range(0, 255)), 4'(prio), 1'($urandom_range(0, 1)));
         prio += $urandom_range(1, 2);
      end
      send_token(8'($urandom_range(0, 255)), PRIO_PAREN, PAREN_CLOSE);
   endtask

   // Result channel back-pressure, changing its character every so often.
   initial begin
      drain_kind_type drain_mode;
      int             phase_left;
      int             stall_left;
      drain_mode = DRAIN_FREE;
      phase_left = 0;
      stall_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (phase_left == 0) begin
            phase_left = $urandom_range(20, 120);
            drain_mode = drain_kind_type'($urandom_range(0, 3));
         end
         phase_left--;
         case (drain_mode)
            DRAIN_FREE:  rsp_chan.ready <= 1'b1;
            DRAIN_LIGHT: rsp_chan.ready <= ($urandom_range(0, 3) != 0);
            DRAIN_HALF:  rsp_chan.ready <= 1'($urandom_range(0, 1));
            default: begin
               if (stall_left > 0) begin
                  rsp_chan.ready <= 1'b0;
                  stall_left--;
               end else begin
                  rsp_chan.ready <= 1'b1;
                  if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 12);
               end
            end
         endcase
      end
   end

   initial begin
      int  pick;
      int  stop_at;
      bit  paused;
      paused = 1'b0;
      reset                 <= 1'b1;
      req_chan.valid        <= 1'b0;
      req_chan.token_code   <= '0;
      req_chan.priority_req <= '0;
      req_chan.is_open      <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Close on an empty stack: a bare unmatched-close report.
      send_token(8'h29, PRIO_PAREN, PAREN_CLOSE);
      // Highest priority and code, with the open bit set but ignored.
      send_token(8'hFF, 4'd15, 1'b1);
      // Lowest priority pops it; code zero is pushed.
      send_token(8'h00, 4'd1, 1'b0);
      send_token(8'h28, PRIO_PAREN, PAREN_OPEN);
      send_token(8'h2B, 4'd7, 1'b0);
      // Equal priority pops the previous operator.
      send_token(8'h2A, 4'd7, 1'b0);
      send_token(8'h29, PRIO_PAREN, PAREN_CLOSE);
      // Nothing open is left, so this close reports on its last pop.
      send_token(8'h29, PRIO_PAREN, PAREN_CLOSE);
      // Fill the stack with parentheses, then push onto it twice.
      for (int i = 0; i < ositp_pkg::STACK_DEPTH; i++)
         send_token(8'(8'h80 + i), PRIO_PAREN, PAREN_OPEN);
      send_token(8'h5A, PRIO_PAREN, PAREN_OPEN);
      send_token(8'hA5, 4'd5, 1'b1);

      stop_at = items_sent + RANDOM_ITEMS;
      while (items_sent < stop_at) begin
         if (!paused && items_sent >= stop_at - RANDOM_ITEMS / 2) begin
            wait_for_drain();
            paused = 1'b1;
         end
         pick = $urandom_range(0, 9);
         if (pick < 6)
            send_expression();
         else if (pick < 7)
            send_ladder();
         else
            send_token(8'($urandom_range(0, 255)),
                       $urandom_range(0, 1) ? PRIO_PAREN : 4'($urandom_range(1, 15)),
                       1'($urandom_range(0, 1)));
      end

      wait_for_drain();
      repeat (40) @(posedge clock);

      $display("tb_top: %0d tokens taken, %0d postfix results compared",
               tokens_seen, results_seen);
      $display("tb_top: %0d unmatched-close and %0d overflow reports among them",
               unmatched_seen, overflow_seen);
      if (mismatch_count == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule
